// File: src/ocu_pkg.sv
package ocu_pkg;

   // sequencer steps, at most one shared multiplier use per step
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PMUL,
      ST_YMUL,
      ST_ZMUL,
      ST_DIST,
      ST_SP,
      ST_CP,
      ST_SY,
      ST_CY,
      ST_HS,
      ST_HC,
      ST_TZ,
      ST_DIR
   } state_type;

   typedef enum logic [2:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_CENTER_Z,
      CSR_PITCH_GAIN,
      CSR_YAW_GAIN,
      CSR_ZOOM_GAIN,
      CSR_MIN_DISTANCE,
      CSR_START_DISTANCE
   } csr_index_type;

   localparam logic signed [15:0] PITCH_LIMIT  = 16'sd16202;
   localparam logic [15:0]        QUARTER_TURN = 16'd16384;
   localparam longint             HALF_PI_Q30  = 64'd1686629713;
   localparam logic signed [17:0] SINE_ONE     = 18'sd65536;

endpackage

// File: src/orbit_camera_update.sv
// orbit camera update: one transaction in, one result transaction out
// the sequencer steps through its states once per transaction; a new input
// is accepted only in idle, after the previous result has left the final
// step, which waits while that result is still stalled at the output; the
// shared 33x18 multiplier and the single sine rom port serve all steps
// reset: synchronous active high, clears angles and camera position, loads
// register defaults and the default orbit distance; rom is constant
module orbit_camera_update #(
   parameter int SMOOTH_SHIFT = 3,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_button_held,
   input  logic signed [15:0] req_mouse_dx,
   input  logic signed [15:0] req_mouse_dy,
   input  logic signed [7:0]  req_wheel_delta,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_dir_x,
   output logic signed [31:0] rsp_dir_y,
   output logic signed [31:0] rsp_dir_z,
   // configuration port
   input  logic               csr_we,
   input  ocu_pkg::csr_index_type csr_index,
   input  logic [31:0]        csr_wdata
);
   import ocu_pkg::*;

   localparam int IDX_W = $clog2(SINE_ENTRIES);

   // configuration registers
   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [15:0]        pitch_gain_ff, yaw_gain_ff;
   logic [30:0]        zoom_gain_ff, min_distance_ff;

   // camera state
   logic signed [15:0] pitch_ff;
   logic [15:0]        yaw_ff;
   logic [30:0]        orbit_ff;
   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff;

   // captured input transaction
   logic               held_ff;
   logic signed [15:0] dx_ff, dy_ff;
   logic signed [7:0]  wheel_ff;

   // sequencer and working registers
   state_type          state_ff, state_in;
   logic signed [50:0] prod_ff;
   logic signed [17:0] sp_ff, cp_ff, sy_ff, cy_ff;
   logic signed [31:0] h_ff;
   logic               full_ff, neg_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] out_pos_x_ff, out_pos_y_ff, out_pos_z_ff;
   logic signed [31:0] out_dir_x_ff, out_dir_y_ff, out_dir_z_ff;

   logic               req_take, out_free;
   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic [15:0]        sin_angle;

   function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
      if (v > 52'sd2147483647) return 32'sh7fffffff;
      if (v < -52'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // move one 2^-shift fraction toward the target, floor rounding
   function automatic logic signed [31:0] smooth(input logic signed [31:0] cur,
                                                 input logic signed [31:0] tgt);
      logic signed [32:0] d;
      logic signed [33:0] s;
      d = 33'(tgt) - 33'(cur);
      s = 34'(cur) + 34'(d >>> SMOOTH_SHIFT);
      return sat32(52'(s));
   endfunction

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_PMUL;
         ST_PMUL: state_in = ST_YMUL;
         ST_YMUL: state_in = ST_ZMUL;
         ST_ZMUL: state_in = ST_DIST;
         ST_DIST: state_in = ST_SP;
         ST_SP:   state_in = ST_CP;
         ST_CP:   state_in = ST_SY;
         ST_SY:   state_in = ST_CY;
         ST_CY:   state_in = ST_HS;
         ST_HS:   state_in = ST_HC;
         ST_HC:   state_in = ST_TZ;
         ST_TZ:   state_in = ST_DIR;
         ST_DIR:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: multiplier operands, sine angle, input stall
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      sin_angle = 16'(pitch_ff);
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_PMUL: begin
            mul_a = 33'(dy_ff);
            mul_b = $signed({2'b00, pitch_gain_ff});
         end
         ST_YMUL: begin
            mul_a = 33'(dx_ff);
            mul_b = $signed({2'b00, yaw_gain_ff});
         end
         ST_ZMUL: begin
            mul_a = $signed({2'b00, zoom_gain_ff});
            mul_b = 18'(wheel_ff);
         end
         ST_SP: sin_angle = 16'(pitch_ff) + QUARTER_TURN;
         ST_CP: sin_angle = yaw_ff;
         ST_SY: begin
            sin_angle = yaw_ff + QUARTER_TURN;
            mul_a     = $signed({2'b00, orbit_ff});
            mul_b     = cp_ff;
         end
         ST_CY: begin
            mul_a = $signed({2'b00, orbit_ff});
            mul_b = sp_ff;
         end
         ST_HS: begin
            mul_a = 33'(h_ff);
            mul_b = sy_ff;
         end
         ST_HC: begin
            mul_a = 33'(h_ff);
            mul_b = cy_ff;
         end
         default: ;
      endcase
   end

   // sine lookup: quadrant folding in front of the rom, sign after it
   logic [14:0]      fold_u;
   logic [31:0]      fold_scaled;
   logic [IDX_W-1:0] rom_addr;
   logic [16:0]      rom_data;
   logic signed [17:0] sin_mag, sin_val;

   assign fold_u      = sin_angle[14] ? (15'd16384 - {1'b0, sin_angle[13:0]})
                                      : {1'b0, sin_angle[13:0]};
   assign fold_scaled = 32'(fold_u[13:0]) * 32'(SINE_ENTRIES);
   assign rom_addr    = fold_scaled[14 +: IDX_W];

   ocu_sine_rom #(
      .ENTRIES (SINE_ENTRIES),
      .WIDTH   (17)
   ) u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .rd_data (rom_data)
   );

   assign sin_mag = full_ff ? SINE_ONE : $signed({1'b0, rom_data});
   assign sin_val = neg_ff ? -sin_mag : sin_mag;

   // angle and distance arithmetic around the multiplier result
   logic signed [25:0] pitch_step, pitch_sum;
   logic signed [15:0] pitch_in;
   logic signed [41:0] dist_sum;
   logic [30:0]        orbit_in;

   assign pitch_step = held_ff ? 26'(prod_ff >>> 8) : '0;
   assign pitch_sum  = 26'(pitch_ff) + pitch_step;

   always_comb begin
      priority if (pitch_sum < 26'(-PITCH_LIMIT)) begin
         pitch_in = -PITCH_LIMIT;
      end else if (pitch_sum > 26'(PITCH_LIMIT)) begin
         pitch_in = PITCH_LIMIT;
      end else begin
         pitch_in = pitch_sum[15:0];
      end
   end

   assign dist_sum = $signed({11'b0, orbit_ff}) - 42'(prod_ff);

   always_comb begin
      priority if (dist_sum > 42'sd2147483647) begin
         orbit_in = 31'h7fffffff;
      end else if (dist_sum < $signed({11'b0, min_distance_ff})) begin
         orbit_in = min_distance_ff;
      end else begin
         orbit_in = dist_sum[30:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DIR && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration registers and camera state
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff       <= '0;
         center_y_ff       <= '0;
         center_z_ff       <= '0;
         pitch_gain_ff     <= 16'd256;
         yaw_gain_ff       <= 16'd256;
         zoom_gain_ff      <= 31'd65536;
         min_distance_ff   <= 31'd65536;
         orbit_ff          <= 31'd655360;
         pitch_ff          <= '0;
         yaw_ff            <= '0;
         cam_x_ff          <= '0;
         cam_y_ff          <= '0;
         cam_z_ff          <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CENTER_X:     center_x_ff     <= $signed(csr_wdata);
               CSR_CENTER_Y:     center_y_ff     <= $signed(csr_wdata);
               CSR_CENTER_Z:     center_z_ff     <= $signed(csr_wdata);
               CSR_PITCH_GAIN:   pitch_gain_ff   <= csr_wdata[15:0];
               CSR_YAW_GAIN:     yaw_gain_ff     <= csr_wdata[15:0];
               CSR_ZOOM_GAIN:    zoom_gain_ff    <= csr_wdata[30:0];
               CSR_MIN_DISTANCE: min_distance_ff <= csr_wdata[30:0];
               CSR_START_DISTANCE: begin
                  // start distance only matters as a re-initialized orbit
                  orbit_ff <= csr_wdata[30:0];
               end
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_YMUL: pitch_ff <= pitch_in;
            ST_ZMUL: if (held_ff) yaw_ff <= yaw_ff - 16'(prod_ff >>> 8);
            ST_DIST: orbit_ff <= orbit_in;
            // y target: centre plus vertical offset
            ST_HS: cam_y_ff <= smooth(cam_y_ff,
                                      sat32(52'(center_y_ff) + 52'(prod_ff >>> 16)));
            // x target: centre minus horizontal times sin yaw
            ST_HC: cam_x_ff <= smooth(cam_x_ff,
                                      sat32(52'(center_x_ff) - 52'(prod_ff >>> 16)));
            // z target: centre minus horizontal times cos yaw
            ST_TZ: cam_z_ff <= smooth(cam_z_ff,
                                      sat32(52'(center_z_ff) - 52'(prod_ff >>> 16)));
            default: ;
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      full_ff <= fold_u[14];
      neg_ff  <= sin_angle[15];
      if (req_take) begin
         held_ff  <= req_button_held;
         dx_ff    <= req_mouse_dx;
         dy_ff    <= req_mouse_dy;
         wheel_ff <= req_wheel_delta;
      end
      unique case (state_ff)
         ST_SP: sp_ff <= sin_val;
         ST_CP: cp_ff <= sin_val;
         ST_SY: sy_ff <= sin_val;
         ST_CY: begin
            cy_ff <= sin_val;
            h_ff  <= 32'(prod_ff >>> 16);
         end
         ST_DIR: if (out_free) begin
            out_pos_x_ff <= cam_x_ff;
            out_pos_y_ff <= cam_y_ff;
            out_pos_z_ff <= cam_z_ff;
            out_dir_x_ff <= sat32(52'(center_x_ff) - 52'(cam_x_ff));
            out_dir_y_ff <= sat32(52'(center_y_ff) - 52'(cam_y_ff));
            out_dir_z_ff <= sat32(52'(center_z_ff) - 52'(cam_z_ff));
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = out_pos_x_ff;
   assign rsp_pos_y = out_pos_y_ff;
   assign rsp_pos_z = out_pos_z_ff;
   assign rsp_dir_x = out_dir_x_ff;
   assign rsp_dir_y = out_dir_y_ff;
   assign rsp_dir_z = out_dir_z_ff;

   // pitch never leaves the clamp range
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      (pitch_ff <= PITCH_LIMIT) && (pitch_ff >= -PITCH_LIMIT))
      else $error("pitch outside clamp range");

   // after the distance step the orbit respects the minimum
   a_orbit_min: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SP) |-> (orbit_ff >= min_distance_ff))
      else $error("orbit distance below minimum");

   // leaving the final step always presents a result
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIR && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not presented");

endmodule

// File: src/ocu_sine_rom.sv
module ocu_sine_rom #(
   parameter int ENTRIES = 1024,
   parameter int WIDTH   = 17
) (
   input  logic                       clock,
   input  logic [$clog2(ENTRIES)-1:0] addr,
   output logic [WIDTH-1:0]           rd_data
);
   import ocu_pkg::*;

   typedef logic [WIDTH-1:0] rom_type [ENTRIES];

   localparam longint DIVS [7] = '{6, 20, 42, 72, 110, 156, 210};

   // quarter-wave sine, taylor series in unsigned q2.30, rounded to q1.16
   function automatic rom_type build_rom();
      rom_type tbl;
      longint  x, x2, term, sum, r;
      for (int i = 0; i < ENTRIES; i++) begin
         x    = (longint'(i) * HALF_PI_Q30) / ENTRIES;
         x2   = (x * x) >>> 30;
         term = x;
         sum  = x;
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >>> 30) / DIVS[k-1];
            if (k % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum <= 0) begin
            r = 0;
         end else begin
            r = (sum + 8192) >>> 14;
            if (r > 65536) r = 65536;
         end
         tbl[i] = WIDTH'(r);
      end
      return tbl;
   endfunction

   localparam rom_type ROM = build_rom();

   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= ROM[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: verif/orbit_camera_update_tb.sv
`timescale 1ns / 100ps

module orbit_camera_update_tb;
   import ocu_pkg::*;

   localparam int SHIFT   = 3;
   localparam int ENTRIES = 1024;
   localparam int RANDOM_PER_PHASE = 80;

   // one camera tick as offered on the input channel
   typedef struct {
      logic              held;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic signed [7:0]  wheel;
   } tick_type;

   // one camera pose as returned on the result channel
   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [31:0] dx, dy, dz;
   } pose_type;

   // directed row: a tick and, where obvious, the pose it must give
   typedef struct {
      tick_type tick;
      bit       typed;
      pose_type pose;
   } row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_button_held;
   logic signed [15:0] req_mouse_dx;
   logic signed [15:0] req_mouse_dy;
   logic signed [7:0]  req_wheel_delta;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic               csr_we;
   csr_index_type      csr_index;
   logic [31:0]        csr_wdata;

   orbit_camera_update #(.SMOOTH_SHIFT(SHIFT), .SINE_ENTRIES(ENTRIES)) uut (.*);

   // ---------------- camera model ----------------
   logic [16:0]        quarter_rom [ENTRIES];
   logic signed [31:0] cen_x, cen_y, cen_z;
   logic [15:0]        gain_pitch, gain_yaw;
   logic [30:0]        gain_zoom, dist_floor, dist_start;
   logic signed [15:0] pitch;
   logic [15:0]        yaw;
   logic [30:0]        orbit_dist;
   logic signed [31:0] cam_x, cam_y, cam_z;

   pose_type pose_queue[$];
   int       mismatches;
   int       poses_seen;
   bit       no_idle;

   // taylor series in unsigned q2.30, rounded to q1.16, capped at one
   function automatic logic [16:0] taylor_sine(int unsigned i);
      longint unsigned x, x2, term, r;
      longint          sum;
      x = longint'(i) * 64'd1686629713 / ENTRIES;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum -= term;
         else sum += term;
      end
      if (sum <= 0) return 0;
      r = (longint'(sum) + 8192) >> 14;
      return (r > 65536) ? 17'd65536 : r[16:0];
   endfunction

   function automatic longint quarter_sin(int unsigned u);
      int unsigned idx;
      if (u >= 16384) return 65536;
      idx = (u * ENTRIES) >> 14;
      if (idx >= ENTRIES) idx = ENTRIES - 1;
      return quarter_rom[idx];
   endfunction

   function automatic longint angle_sin(logic [15:0] a);
      int unsigned r;
      r = a[13:0];
      case (a[15:14])
         2'd0: return quarter_sin(r);
         2'd1: return quarter_sin(16384 - r);
         2'd2: return -quarter_sin(r);
         default: return -quarter_sin(16384 - r);
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] glide(logic signed [31:0] cur, longint target);
      return sat32(longint'(cur) + ((target - longint'(cur)) >>> SHIFT));
   endfunction

   task automatic camera_reset();
      cen_x = 0; cen_y = 0; cen_z = 0;
      gain_pitch = 256; gain_yaw = 256;
      gain_zoom = 65536; dist_floor = 65536; dist_start = 655360;
      pitch = 0; yaw = 0; orbit_dist = dist_start;
      cam_x = 0; cam_y = 0; cam_z = 0;
   endtask

   // advances the model by one tick and returns the pose it gives
   function automatic pose_type camera_step(tick_type t);
      longint   p, d, sp, cp, sy, cy, h, v;
      pose_type r;
      p = pitch;
      if (t.held) begin
         p += (longint'(t.dy) * longint'(gain_pitch)) >>> 8;
         yaw = yaw - 16'((longint'(t.dx) * longint'(gain_yaw)) >>> 8);
      end
      if (p < -16202) p = -16202;
      if (p > 16202) p = 16202;
      pitch = p[15:0];
      d = longint'(orbit_dist) - longint'(t.wheel) * longint'(gain_zoom);
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < longint'(dist_floor)) d = dist_floor;
      orbit_dist = d[30:0];
      sp = angle_sin(pitch);
      cp = angle_sin(pitch + 16'd16384);
      sy = angle_sin(yaw);
      cy = angle_sin(yaw + 16'd16384);
      h = (d * cp) >>> 16;
      v = (d * sp) >>> 16;
      cam_x = glide(cam_x, sat32(longint'(cen_x) - ((h * sy) >>> 16)));
      cam_y = glide(cam_y, sat32(longint'(cen_y) + v));
      cam_z = glide(cam_z, sat32(longint'(cen_z) - ((h * cy) >>> 16)));
      r.px = cam_x; r.py = cam_y; r.pz = cam_z;
      r.dx = sat32(longint'(cen_x) - cam_x);
      r.dy = sat32(longint'(cen_y) - cam_y);
      r.dz = sat32(longint'(cen_z) - cam_z);
      return r;
   endfunction

   // ---------------- clock, limit ----------------
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 18);
   endfunction

   // ---------------- configuration ----------------
   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CENTER_X: cen_x = data;
         CSR_CENTER_Y: cen_y = data;
         CSR_CENTER_Z: cen_z = data;
         CSR_PITCH_GAIN: gain_pitch = data[15:0];
         CSR_YAW_GAIN: gain_yaw = data[15:0];
         CSR_ZOOM_GAIN: gain_zoom = data[30:0];
         CSR_MIN_DISTANCE: dist_floor = data[30:0];
         CSR_START_DISTANCE: begin
            dist_start = data[30:0];
            orbit_dist = data[30:0];
         end
         default: ;
      endcase
   endtask

   task automatic configure(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] pg, logic [31:0] yg, logic [31:0] zg,
                            logic [31:0] md, logic [31:0] sd);
      csr_write(CSR_CENTER_X, cx);
      csr_write(CSR_CENTER_Y, cy);
      csr_write(CSR_CENTER_Z, cz);
      csr_write(CSR_PITCH_GAIN, pg);
      csr_write(CSR_YAW_GAIN, yg);
      csr_write(CSR_ZOOM_GAIN, zg);
      csr_write(CSR_MIN_DISTANCE, md);
      csr_write(CSR_START_DISTANCE, sd);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for every pose to come back, then for the sequencer to settle
   task automatic drain();
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // ---------------- input channel ----------------
   task automatic send_tick(tick_type t, bit typed, pose_type typed_pose);
      int       gap;
      pose_type p;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_button_held <= t.held;
      req_mouse_dx <= t.dx;
      req_mouse_dy <= t.dy;
      req_wheel_delta <= t.wheel;
      do @(posedge clock); while (req_stall);
      p = camera_step(t);
      pose_queue.push_back(typed ? typed_pose : p);
   endtask

   function automatic tick_type random_tick();
      tick_type t;
      t.held = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 3))
         0: begin
            t.dx = $urandom; t.dy = $urandom;
         end
         default: begin
            t.dx = $urandom_range(0, 400) - 200;
            t.dy = $urandom_range(0, 400) - 200;
         end
      endcase
      t.wheel = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6) - 3);
      return t;
   endfunction

   task automatic random_phase();
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
         send_tick(random_tick(), 1'b0, '{default: 0});
      end
      no_idle = 0;
      req_valid <= 1'b0;
   endtask

   // ---------------- directed table ----------------
   row_type rows[] = '{
      // first tick from reset: distance 10 straight behind the centre
      '{'{1'b0, 16'sd0, 16'sd0, 8'sd0}, 1'b1, '{0, 0, -81920, 0, 0, 81920}},
      '{'{1'b1, 16'sd0, 16'sd32767, 8'sd0}, 1'b0, '{default: 0}},
      '{'{1'b1, 16'sd0, 16'sd32767, 8'sd0}, 1'b0, '{default: 0}},
      '{'{1'b1, 16'sd0, -16'sd32768, 8'sd0}, 1'b0, '{default: 0}},
      '{'{1'b1, 16'sd0, -16'sd32768, 8'sd0}, 1'b0, '{default: 0}},
      '{'{1'b1, 16'sd32767, 16'sd0, 8'sd0}, 1'b0, '{default: 0}},
      '{'{1'b1, -16'sd32768, 16'sd0, 8'sd0}, 1'b0, '{default: 0}},
      // button up: deltas ignored
      '{'{1'b0, -16'sd32768, 16'sd32767, 8'sd0}, 1'b0, '{default: 0}},
      // yaw steps a quarter turn at a time across the quadrant edges
      '{'{1'b1, -16'sd16384, 16'sd0, 8'sd0}, 1'b0, '{default: 0}},
      '{'{1'b1, -16'sd16384, 16'sd0, 8'sd0}, 1'b0, '{default: 0}},
      '{'{1'b1, -16'sd16384, 16'sd0, 8'sd0}, 1'b0, '{default: 0}},
      '{'{1'b1, -16'sd16384, 16'sd0, 8'sd0}, 1'b0, '{default: 0}},
      '{'{1'b1, -16'sd1, 16'sd1, 8'sd0}, 1'b0, '{default: 0}},
      // zoom in to the floor, then out
      '{'{1'b0, 16'sd0, 16'sd0, 8'sd127}, 1'b0, '{default: 0}},
      '{'{1'b0, 16'sd0, 16'sd0, 8'sd127}, 1'b0, '{default: 0}},
      '{'{1'b0, 16'sd0, 16'sd0, -8'sd128}, 1'b0, '{default: 0}},
      '{'{1'b0, 16'sd0, 16'sd0, -8'sd128}, 1'b0, '{default: 0}},
      '{'{1'b1, 16'sd7, -16'sd9, -8'sd1}, 1'b0, '{default: 0}}
   };

   // ---------------- stimulus ----------------
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_button_held = 1'b0;
      req_mouse_dx = '0;
      req_mouse_dy = '0;
      req_wheel_delta = '0;
      csr_we = 1'b0;
      csr_index = CSR_CENTER_X;
      csr_wdata = '0;
      mismatches = 0;
      no_idle = 0;
      for (int i = 0; i < ENTRIES; i++) quarter_rom[i] = taylor_sine(i);
      camera_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // defaults written back explicitly, then the directed rows
      configure(0, 0, 0, 256, 256, 65536, 65536, 655360);
      foreach (rows[i]) send_tick(rows[i].tick, rows[i].typed, rows[i].pose);
      req_valid <= 1'b0;
      random_phase();
      drain();  // sender waits for every pose before reprogramming

      // centre at the top corner in x and y, bottom in z, maximum gains, zoom saturating high
      configure(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'hffff, 32'hffff,
                32'hffffffff, 32'h7fffffff, 32'h7fffffff);
      random_phase();
      drain();

      // centre at the bottom corner in x and y, top in z, zero gains and zero floor
      configure(32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0);
      random_phase();
      drain();

      // random setting, modest distances
      configure($urandom, $urandom, $urandom, $urandom_range(0, 2048),
                $urandom_range(0, 2048), $urandom_range(0, 1 << 20),
                $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 24));
      random_phase();
      drain();

      // fully random setting
      configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
      random_phase();
      drain();

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ---------------- result channel ----------------
   initial begin
      int       hold;
      pose_type want;
      rsp_stall = 1'b0;
      poses_seen = 0;
      forever begin
         // one long hold-off so the block backs up into its input
         hold = (poses_seen == 60) ? 300 : draw_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid || reset);
         poses_seen++;
         if (pose_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pose transaction");
         end else begin
            want = pose_queue.pop_front();
            if (rsp_pos_x !== want.px || rsp_pos_y !== want.py ||
                rsp_pos_z !== want.pz || rsp_dir_x !== want.dx ||
                rsp_dir_y !== want.dy || rsp_dir_z !== want.dz) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"pose %0d: want pos %0d %0d %0d dir %0d %0d %0d,",
                            " got pos %0d %0d %0d dir %0d %0d %0d"},
                           poses_seen, want.px, want.py, want.pz, want.dx, want.dy,
                           want.dz, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_dir_x,
                           rsp_dir_y, rsp_dir_z);
            end
         end
      end
   end

endmodule

// File: orbit_camera_update.f
src/ocu_pkg.sv
src/ocu_sine_rom.sv
src/orbit_camera_update.sv
verif/orbit_camera_update_tb.sv
